// ===== hdl/irac_pkg.sv =====
// Shared types, timing windows and result codes for the IR air-conditioner frame decoder.
// No dependencies; imported by every module of the decoder.
`default_nettype none

package irac_pkg;

    // Nominal pulse times in microseconds
    localparam int unsigned HdrMarkUs   = 6200;
    localparam int unsigned HdrSpaceUs  = 7480;
    localparam int unsigned BitMarkUs   = 560;
    localparam int unsigned OneSpaceUs  = 1640;
    localparam int unsigned ZeroSpaceUs = 550;
    localparam int unsigned TolLo       = 75;
    localparam int unsigned TolHi       = 125;

    // Acceptance windows, -25% .. +25% with integer truncation
    localparam logic [15:0] HDR_MARK_LO   = 16'(HdrMarkUs * TolLo / 100);
    localparam logic [15:0] HDR_MARK_HI   = 16'(HdrMarkUs * TolHi / 100);
    localparam logic [15:0] HDR_SPACE_LO  = 16'(HdrSpaceUs * TolLo / 100);
    localparam logic [15:0] HDR_SPACE_HI  = 16'(HdrSpaceUs * TolHi / 100);
    localparam logic [15:0] BIT_MARK_LO   = 16'(BitMarkUs * TolLo / 100);
    localparam logic [15:0] BIT_MARK_HI   = 16'(BitMarkUs * TolHi / 100);
    localparam logic [15:0] ONE_SPACE_LO  = 16'(OneSpaceUs * TolLo / 100);
    localparam logic [15:0] ONE_SPACE_HI  = 16'(OneSpaceUs * TolHi / 100);
    localparam logic [15:0] ZERO_SPACE_LO = 16'(ZeroSpaceUs * TolLo / 100);
    localparam logic [15:0] ZERO_SPACE_HI = 16'(ZeroSpaceUs * TolHi / 100);

    // Frame content constants
    localparam logic [7:0] TIMER_MIN = 8'hA1;
    localparam logic [7:0] TIMER_MAX = 8'hB8;
    localparam logic [7:0] TIMER_CMD = 8'h0D;

    // Positions within a capture
    localparam logic [7:0] POS_HDR_MARK   = 8'd0;
    localparam logic [7:0] POS_HDR_SPACE  = 8'd1;
    localparam logic [7:0] POS_FIRST_BIT  = 8'd2;
    localparam logic [7:0] POS_LAST_BIT   = 8'd193;
    localparam logic [7:0] POS_FOOT_MARK  = 8'd194;
    localparam logic [7:0] POS_FOOT_SPACE = 8'd195;
    localparam logic [7:0] POS_FINAL      = 8'd196;

    localparam int unsigned FRAME_BYTES = 5;

    typedef enum logic [3:0] {
        OC_OK       = 4'd0,
        OC_TIMER    = 4'd1,
        OC_SHORT    = 4'd2,
        OC_HEADER   = 4'd3,
        OC_BITMARK  = 4'd4,
        OC_BITSPACE = 4'd5,
        OC_FOOTER   = 4'd6,
        OC_FINAL    = 4'd7,
        OC_COMPL    = 4'd8
    } outcome_t;

    localparam logic [2:0] MODE_AUTO = 3'd0;
    localparam logic [2:0] MODE_HEAT = 3'd4;
    localparam logic [2:0] MODE_OFF  = 3'd5;

    localparam logic [1:0] PRESET_NONE  = 2'd0;
    localparam logic [1:0] PRESET_SLEEP = 2'd1;
    localparam logic [1:0] PRESET_BOOST = 2'd2;
    localparam logic [1:0] PRESET_LIGHT = 2'd3;

    // Window matches for one pulse duration
    typedef struct packed {
        logic lead_mark;
        logic lead_gap;
        logic data_mark;
        logic one_gap;
        logic zero_gap;
    } pulse_match_t;

    // One result beat; first member lands in the top bits of tdata
    typedef struct packed {
        logic [7:0] command_byte;
        logic [4:0] timer_hours;
        logic [1:0] preset_code;
        logic       louver_swing;
        logic [1:0] fan_code;
        logic [5:0] target_temp;
        logic [2:0] hvac_mode;
        logic       power_on;
        outcome_t   outcome;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/irac_classify.sv =====
// Pulse classifier: takes the magnitude of a signed duration and checks it
// against every timing window. Depends on irac_pkg.
`default_nettype none

module irac_classify
    import irac_pkg::*;
(
    input  wire logic [16:0]  duration_us,
    output pulse_match_t      match
);

    logic [16:0] neg;
    logic [15:0] mag;

    // Take magnitude; the most negative code clamps to full scale
    assign neg = 17'(~duration_us + 17'd1);
    always_comb
    begin
        if (!duration_us[16])
            mag = duration_us[15:0];
        else if (neg[16])
            mag = 16'hFFFF;
        else
            mag = neg[15:0];
    end

    // Compare against each window
    assign match.lead_mark = (mag >= HDR_MARK_LO)   && (mag <= HDR_MARK_HI);
    assign match.lead_gap  = (mag >= HDR_SPACE_LO)  && (mag <= HDR_SPACE_HI);
    assign match.data_mark = (mag >= BIT_MARK_LO)   && (mag <= BIT_MARK_HI);
    assign match.one_gap   = (mag >= ONE_SPACE_LO)  && (mag <= ONE_SPACE_HI);
    assign match.zero_gap  = (mag >= ZERO_SPACE_LO) && (mag <= ZERO_SPACE_HI);

endmodule

`default_nettype wire

// ===== hdl/irac_fields.sv =====
// Frame field decoder: turns the five stored frame bytes and the complement
// check into the final result beat. Depends on irac_pkg.
`default_nettype none

module irac_fields
    import irac_pkg::*;
(
    input  wire logic [7:0] timer_byte,
    input  wire logic [7:0] extra_byte,
    input  wire logic [7:0] cmd_byte,
    input  wire logic [7:0] status_byte,
    input  wire logic [7:0] mode_byte,
    input  wire logic       pair_mismatch,
    output result_t         result
);

    logic       timer_ok;
    logic [2:0] mode_raw;

    assign timer_ok = (timer_byte >= TIMER_MIN) && (timer_byte <= TIMER_MAX);
    assign mode_raw = mode_byte[7:5];

    // Build the result; rejects and timer frames leave other fields clear
    always_comb
    begin
        result = '0;
        if (pair_mismatch)
        begin
            result.outcome = OC_COMPL;
        end
        else if (!timer_ok && (cmd_byte == TIMER_CMD))
        begin
            result.outcome      = OC_TIMER;
            result.command_byte = cmd_byte;
        end
        else
        begin
            result.outcome  = OC_OK;
            result.power_on = status_byte[1];
            if (!status_byte[1])
                result.hvac_mode = MODE_OFF;
            else if (mode_raw > MODE_HEAT)
                result.hvac_mode = MODE_AUTO;
            else
                result.hvac_mode = mode_raw;
            result.target_temp  = 6'({1'b0, mode_byte[4:0]} + 6'd16);
            result.fan_code     = status_byte[6:5];
            result.louver_swing = (status_byte[3:2] == 2'b01);
            if (status_byte[0])
                result.preset_code = PRESET_SLEEP;
            else if (extra_byte[3])
                result.preset_code = PRESET_BOOST;
            else if (extra_byte[0])
                result.preset_code = PRESET_LIGHT;
            else
                result.preset_code = PRESET_NONE;
            result.timer_hours  = timer_ok ? timer_byte[4:0] : 5'd0;
            result.command_byte = cmd_byte;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ir_ac_frame_decoder.sv =====
// IR air-conditioner frame decoder, top level: input register, capture
// sequencer with frame storage, and result register. Depends on irac_pkg,
// irac_classify and irac_fields.
// Flow: a beat is held in the input register, decided as it moves on, and
// its result beat is held in the result register. Throughput: one beat per cycle
// while the result side keeps up; at most one result beat per capture.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// sequencer to the header position.
`default_nettype none

module ir_ac_frame_decoder
    import irac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [16:0] duration_us, [23:17] zero
    input  wire logic        s_tlast,   // last_item
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [3:0] outcome, [4] power_on, [7:5] hvac_mode,
                                        // [13:8] target_temp, [15:14] fan_code,
                                        // [16] louver_swing, [18:17] preset_code,
                                        // [23:19] timer_hours, [31:24] command_byte
);

    // Input register
    logic        in_valid_reg, in_valid_next;
    logic [16:0] in_dur_reg;
    logic        in_last_reg;

    // Capture state
    logic [7:0] pos_reg, pos_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] even_reg, even_next;
    logic       mismatch_reg, mismatch_next;
    logic       decided_reg, decided_next;
    logic [7:0] frame_reg [FRAME_BYTES];

    // Result register
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;

    logic         s_beat;
    logic         advance;
    pulse_match_t match;
    result_t      fin_result;

    logic       emit;
    logic       finish;
    outcome_t   code;
    logic       take;
    logic       bit_val;
    logic [6:0] bit_num;
    logic [2:0] bit_idx;
    logic [3:0] byte_idx;
    logic [7:0] shift_or;
    logic       frame_we;
    logic [2:0] frame_sel;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    irac_classify u_classify
    (
        .duration_us (in_dur_reg),
        .match       (match)
    );

    irac_fields u_fields
    (
        .timer_byte    (frame_reg[0]),
        .extra_byte    (frame_reg[1]),
        .cmd_byte      (frame_reg[2]),
        .status_byte   (frame_reg[3]),
        .mode_byte     (frame_reg[4]),
        .pair_mismatch (mismatch_reg),
        .result        (fin_result)
    );

    // Bit position within the data section
    assign bit_num  = 7'((pos_reg - POS_FIRST_BIT) >> 1);
    assign bit_idx  = bit_num[2:0];
    assign byte_idx = bit_num[6:3];
    assign shift_or = shift_reg | (8'(bit_val) << bit_idx);

    // Step the capture sequencer for the beat in the input register
    always_comb
    begin
        emit          = 1'b0;
        finish        = 1'b0;
        code          = OC_OK;
        take          = 1'b0;
        bit_val       = 1'b0;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        even_next     = even_reg;
        mismatch_next = mismatch_reg;
        decided_next  = decided_reg;
        frame_we      = 1'b0;
        frame_sel     = byte_idx[3:1];

        if (!decided_reg)
        begin
            if (pos_reg == POS_HDR_MARK)
            begin
                if (in_last_reg)
                begin
                    emit = 1'b1;
                    code = OC_SHORT;
                end
                else if (!match.lead_mark)
                begin
                    emit = 1'b1;
                    code = OC_HEADER;
                end
            end
            else if (pos_reg == POS_HDR_SPACE)
            begin
                if (!match.lead_gap)
                begin
                    emit = 1'b1;
                    code = OC_HEADER;
                end
                else if (in_last_reg)
                begin
                    emit = 1'b1;
                    code = OC_SHORT;
                end
            end
            else if (pos_reg <= POS_LAST_BIT)
            begin
                if (!pos_reg[0])
                begin
                    if (in_last_reg)
                    begin
                        emit = 1'b1;
                        code = OC_SHORT;
                    end
                    else if (!match.data_mark)
                    begin
                        emit = 1'b1;
                        code = OC_BITMARK;
                    end
                end
                else
                begin
                    if (match.one_gap)
                    begin
                        take    = 1'b1;
                        bit_val = 1'b1;
                    end
                    else if (match.zero_gap)
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        emit = 1'b1;
                        code = OC_BITSPACE;
                    end
                    if (!emit && in_last_reg)
                    begin
                        emit = 1'b1;
                        code = OC_SHORT;
                    end
                end
            end
            else if (pos_reg == POS_FOOT_MARK)
            begin
                if (in_last_reg)
                begin
                    emit = 1'b1;
                    code = OC_SHORT;
                end
                else if (!match.data_mark)
                begin
                    emit = 1'b1;
                    code = OC_FOOTER;
                end
            end
            else if (pos_reg == POS_FOOT_SPACE)
            begin
                // Footer space shares the header space window
                if (!match.lead_gap)
                begin
                    emit = 1'b1;
                    code = OC_FOOTER;
                end
                else if (in_last_reg)
                begin
                    emit = 1'b1;
                    code = OC_FINAL;
                end
            end
            else
            begin
                emit = 1'b1;
                if (!match.data_mark)
                    code = OC_FINAL;
                else
                    finish = 1'b1;
            end

            // Shift in a data bit; close the byte on its eighth bit
            if (take)
            begin
                shift_next = shift_or;
                if (bit_idx == 3'd7)
                begin
                    shift_next = 8'd0;
                    if (!byte_idx[0])
                        even_next = shift_or;
                    else
                    begin
                        if (even_reg != ~shift_or)
                            mismatch_next = 1'b1;
                        frame_we = (byte_idx[3:1] < 3'(FRAME_BYTES));
                    end
                end
            end

            if (emit)
                decided_next = 1'b1;
            else if (pos_reg < POS_FINAL)
                pos_next = pos_reg + 8'd1;
        end

        // Drop the sequencer's capture state (not the frame bytes) at the end of a capture
        if (in_last_reg)
        begin
            pos_next      = POS_HDR_MARK;
            shift_next    = 8'd0;
            even_next     = 8'd0;
            mismatch_next = 1'b0;
            decided_next  = 1'b0;
        end
    end

    // Select the result beat contents
    always_comb
    begin
        out_next = '0;
        if (finish)
            out_next = fin_result;
        else
            out_next.outcome = code;
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_beat)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_HDR_MARK;
            shift_reg     <= 8'd0;
            even_reg      <= 8'd0;
            mismatch_reg  <= 1'b0;
            decided_reg   <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pos_reg      <= pos_next;
                shift_reg    <= shift_next;
                even_reg     <= even_next;
                mismatch_reg <= mismatch_next;
                decided_reg  <= decided_next;
            end
        end
    end

    // Payload: input beat, frame bytes, result beat
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_dur_reg  <= s_tdata[16:0];
            in_last_reg <= s_tlast;
        end
        if (advance && frame_we)
            frame_reg[frame_sel] <= shift_or;
        if (advance)
            out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_ir_ac_frame_decoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ir_ac_frame_decoder: drives pulse-duration beats,
// predicts each capture's decode and checks every result beat field by field.
// Depends on irac_pkg and the ir_ac_frame_decoder RTL.

module tb_ir_ac_frame_decoder
    import irac_pkg::*;
();

    localparam int unsigned FootSpaceUs  = 7480;
    localparam int unsigned STALL_CYCLES = 400;

    // Expected decodes: tracks the capture sequence and queues one result per capture
    class irac_decode_board;
        logic [7:0] slot;
        logic [7:0] byte_acc;
        logic [7:0] inv_byte;
        logic [7:0] frame_store[FRAME_BYTES];
        bit         pair_bad;
        bit         settled;
        result_t    pending_decodes[$];
        int unsigned faults;

        function new();
            clear();
            faults = 0;
        endfunction

        function void clear();
            slot     = POS_HDR_MARK;
            byte_acc = '0;
            inv_byte = '0;
            foreach (frame_store[k]) frame_store[k] = '0;
            pair_bad = 1'b0;
            settled  = 1'b0;
        endfunction

        function bit near(int unsigned mag, int unsigned target);
            return mag >= target * TolLo / 100 && mag <= target * TolHi / 100;
        endfunction

        function void post(result_t r);
            settled = 1'b1;
            pending_decodes.push_back(r);
        endfunction

        function void reject(outcome_t oc);
            result_t r;
            r = '0;
            r.outcome = oc;
            post(r);
        endfunction

        // Advance the capture by one beat; return 0 when the beat is ignored
        function bit note_pulse(logic [16:0] raw, logic last);
            logic [16:0] abs17;
            int unsigned mag;
            int unsigned nbit;
            logic [7:0] p;
            bit         live;
            bit         timer;
            bit         power;
            logic [2:0] md;
            result_t    r;
            live  = !settled;
            p     = slot;
            abs17 = raw[16] ? 17'(17'h0 - raw) : raw;
            mag   = (abs17 > 17'h0FFFF) ? 65535 : int'(abs17);
            if (live) begin
                if (p == POS_HDR_MARK) begin
                    if (last) reject(OC_SHORT);
                    else if (!near(mag, HdrMarkUs)) reject(OC_HEADER);
                end else if (p == POS_HDR_SPACE) begin
                    if (!near(mag, HdrSpaceUs)) reject(OC_HEADER);
                    else if (last) reject(OC_SHORT);
                end else if (p <= POS_LAST_BIT && !p[0]) begin
                    if (last) reject(OC_SHORT);
                    else if (!near(mag, BitMarkUs)) reject(OC_BITMARK);
                end else if (p <= POS_LAST_BIT) begin
                    // Shift in a data bit, LSB first; check each pair on its true byte
                    if (near(mag, OneSpaceUs) || near(mag, ZeroSpaceUs)) begin
                        nbit = (p - POS_FIRST_BIT) >> 1;
                        if (near(mag, OneSpaceUs)) byte_acc[nbit % 8] = 1'b1;
                        if (nbit % 8 == 7) begin
                            if ((nbit / 8) % 2 == 0) begin
                                inv_byte = byte_acc;
                            end else begin
                                if (inv_byte != ~byte_acc) pair_bad = 1'b1;
                                if (nbit / 16 < FRAME_BYTES) frame_store[nbit / 16] = byte_acc;
                            end
                            byte_acc = '0;
                        end
                    end else begin
                        reject(OC_BITSPACE);
                    end
                    if (!settled && last) reject(OC_SHORT);
                end else if (p == POS_FOOT_MARK) begin
                    if (last) reject(OC_SHORT);
                    else if (!near(mag, BitMarkUs)) reject(OC_FOOTER);
                end else if (p == POS_FOOT_SPACE) begin
                    if (!near(mag, FootSpaceUs)) reject(OC_FOOTER);
                    else if (last) reject(OC_FINAL);
                end else begin
                    // Final mark: decode the stored frame
                    timer = frame_store[0] >= TIMER_MIN && frame_store[0] <= TIMER_MAX;
                    if (!near(mag, BitMarkUs)) begin
                        reject(OC_FINAL);
                    end else if (pair_bad) begin
                        reject(OC_COMPL);
                    end else if (!timer && frame_store[2] == TIMER_CMD) begin
                        r = '0;
                        r.outcome      = OC_TIMER;
                        r.command_byte = frame_store[2];
                        post(r);
                    end else begin
                        power = frame_store[3][1];
                        md    = frame_store[4][7:5];
                        if (md > MODE_HEAT) md = MODE_AUTO;
                        if (!power) md = MODE_OFF;
                        r = '0;
                        r.outcome      = OC_OK;
                        r.power_on     = power;
                        r.hvac_mode    = md;
                        r.target_temp  = 6'(frame_store[4][4:0]) + 6'd16;
                        r.fan_code     = frame_store[3][6:5];
                        r.louver_swing = frame_store[3][3:2] == 2'b01;
                        if (frame_store[3][0])      r.preset_code = PRESET_SLEEP;
                        else if (frame_store[1][3]) r.preset_code = PRESET_BOOST;
                        else if (frame_store[1][0]) r.preset_code = PRESET_LIGHT;
                        else                        r.preset_code = PRESET_NONE;
                        r.timer_hours  = timer ? frame_store[0][4:0] : 5'd0;
                        r.command_byte = frame_store[2];
                        post(r);
                    end
                end
                if (!settled && slot < POS_FINAL) slot = slot + 8'd1;
            end
            if (last) clear();
            return live;
        endfunction

        function void compare(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        // Check one result beat against the oldest expected decode
        function void check_decode(logic [31:0] beat);
            result_t got;
            result_t want;
            got = result_t'(beat);
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual %h", $time, beat);
                faults++;
                return;
            end
            want = pending_decodes.pop_front();
            compare("outcome", want.outcome, got.outcome);
            compare("power_on", want.power_on, got.power_on);
            compare("hvac_mode", want.hvac_mode, got.hvac_mode);
            compare("target_temp", want.target_temp, got.target_temp);
            compare("fan_code", want.fan_code, got.fan_code);
            compare("louver_swing", want.louver_swing, got.louver_swing);
            compare("preset_code", want.preset_code, got.preset_code);
            compare("timer_hours", want.timer_hours, got.timer_hours);
            compare("command_byte", want.command_byte, got.command_byte);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [16:0] duration_us, [23:17] zero
    logic        s_tlast = 1'b0; // last_item
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [3:0] outcome, [4] power_on, [7:5] hvac_mode,
                                 // [13:8] target_temp, [15:14] fan_code, [16] louver_swing,
                                 // [18:17] preset_code, [23:19] timer_hours,
                                 // [31:24] command_byte

    irac_decode_board board = new();
    int  pulse_train[$];
    bit  idle_en = 1'b1;
    bit  stall_sink = 1'b0;
    int  live_items = 0;

    ir_ac_frame_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly no gap, a few short ones and rarely a long one
    function automatic int unsigned pick_gap();
        if (!idle_en || $urandom_range(0, 3) != 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
    endfunction

    // Duration inside the window of a nominal time, edges favored, either sign
    function automatic int pulse_near(int unsigned target);
        int unsigned lo;
        int unsigned hi;
        int mag;
        lo = target * TolLo / 100;
        hi = target * TolHi / 100;
        case ($urandom_range(0, 9))
            0:       mag = lo;
            1:       mag = hi;
            default: mag = $urandom_range(lo, hi);
        endcase
        return ($urandom_range(0, 4) == 0) ? -mag : mag;
    endfunction

    // Duration that usually misses the window expected at a given position
    function automatic int pulse_miss(int spot);
        int unsigned t;
        int mag;
        if (spot == 0) t = HdrMarkUs;
        else if (spot == 1) t = HdrSpaceUs;
        else if (spot == 195) t = FootSpaceUs;
        else if (spot <= 193 && spot[0]) t = $urandom_range(0, 1) ? OneSpaceUs : ZeroSpaceUs;
        else t = BitMarkUs;
        case ($urandom_range(0, 3))
            0:       mag = t * TolLo / 100 - 1;
            1:       mag = t * TolHi / 100 + 1;
            2:       mag = $urandom_range(0, 65535);
            default: mag = 0;
        endcase
        return ($urandom_range(0, 3) == 0) ? -mag : mag;
    endfunction

    // Frame content: timer, extra, command, status, mode and a spare byte
    function automatic void random_content(output logic [7:0] c[6]);
        foreach (c[k]) c[k] = 8'($urandom);
        if ($urandom_range(0, 4) < 2) c[0] = 8'($urandom_range(8'hA0, 8'hB9));
        if ($urandom_range(0, 9) < 3) c[2] = TIMER_CMD;
    endfunction

    // Full capture of a frame; flip >= 0 inverts that wire bit
    function automatic void build_frame(input logic [7:0] c[6], input int flip);
        logic [7:0] w;
        int k;
        int b;
        pulse_train.delete();
        pulse_train.push_back(pulse_near(HdrMarkUs));
        pulse_train.push_back(pulse_near(HdrSpaceUs));
        for (k = 0; k < 12; k++) begin
            w = k[0] ? c[k / 2] : ~c[k / 2];
            for (b = 0; b < 8; b++) begin
                pulse_train.push_back(pulse_near(BitMarkUs));
                pulse_train.push_back(pulse_near((w[b] ^ (flip == k * 8 + b)) ?
                                                 OneSpaceUs : ZeroSpaceUs));
            end
        end
        pulse_train.push_back(pulse_near(BitMarkUs));
        pulse_train.push_back(pulse_near(FootSpaceUs));
        pulse_train.push_back(pulse_near(BitMarkUs));
    endfunction

    // Drive one beat at the falling edge and hold it until accepted
    task automatic send_pulse(input int dur, input bit last);
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, 17'(dur)};
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_train();
        int i;
        for (i = 0; i < pulse_train.size(); i++) send_pulse(pulse_train[i], i == pulse_train.size() - 1);
    endtask

    // One random capture: mostly whole frames, some damaged, some noise
    task automatic send_random_capture();
        logic [7:0] c[6];
        int kind;
        int spot;
        idle_en = $urandom_range(0, 3) != 0;
        kind = $urandom_range(0, 99);
        if (kind >= 90) begin
            pulse_train.delete();
            repeat ($urandom_range(1, 8)) pulse_train.push_back(int'($urandom_range(0, 131071)) - 65536);
        end else begin
            random_content(c);
            build_frame(c, (kind >= 45 && kind < 60) ? int'($urandom_range(0, 95)) : -1);
            if ($urandom_range(0, 9) < 3) begin
                case ($urandom_range(0, 4))
                    0: spot = 0;
                    1: spot = 1;
                    2: spot = 194;
                    3: spot = 195;
                    default: spot = 196;
                endcase
            end else begin
                spot = $urandom_range(0, 196);
            end
            if (kind >= 60 && kind < 75) begin
                // Cut the capture short, sometimes on a bad pulse
                spot = (spot == 196) ? 195 : spot;
                while (pulse_train.size() > spot + 1) void'(pulse_train.pop_back());
                if ($urandom_range(0, 1)) pulse_train[spot] = pulse_miss(spot);
            end else if (kind >= 75) begin
                pulse_train[spot] = pulse_miss(spot);
            end else if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 4)) pulse_train.push_back(int'($urandom_range(0, 65535)));
            end
        end
        send_train();
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (m_tvalid && m_tready) board.check_decode(m_tdata);
            if (s_tvalid && s_tready) begin
                if (board.note_pulse(s_tdata[16:0], s_tlast)) live_items = live_items + 1;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned rx_gap;
        rx_gap = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (stall_sink) begin
                m_tready = 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
                m_tready = 1'b1;
                stall_sink = 1'b0;
            end else if (rx_gap != 0) begin
                m_tready = 1'b0;
                rx_gap--;
            end else begin
                m_tready = 1'b1;
                rx_gap = pick_gap();
            end
        end
    end

    // Main sequence
    initial
    begin
        logic [7:0] c[6];
        int waited;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Short captures: most negative duration, bad mark as last beat, window edges
        pulse_train = '{-65536};                    send_train();
        pulse_train = '{100};                       send_train();
        pulse_train = '{65535, 0};                  send_train();
        pulse_train = '{4650, 9350};                send_train();
        pulse_train = '{7750, 5609};                send_train();
        pulse_train = '{-6200, -7480, 560};         send_train();
        pulse_train = '{6200, 7480, 419, 0};        send_train();
        pulse_train = '{6200, 7480, 700, 688};      send_train();
        pulse_train = '{6200, 7480, 420, 2050};     send_train();
        pulse_train = '{6200, 7480, 560, 412, 560, 1230, 701, 0}; send_train();

        // Timer-mode frame with beats trailing the final mark
        c = '{8'h00, 8'h00, TIMER_CMD, 8'hFF, 8'hFF, 8'h00};
        build_frame(c, -1);
        repeat (3) pulse_train.push_back(pulse_near(BitMarkUs));
        send_train();

        // Capture ending on the footer space
        random_content(c);
        build_frame(c, -1);
        void'(pulse_train.pop_back());
        send_train();

        // Accepted frame at the field extremes
        c = '{TIMER_MAX, 8'h09, 8'hFF, 8'h0E, 8'hFF, 8'h00};
        build_frame(c, -1);
        send_train();

        // Hold the result side off while single-beat captures keep coming
        idle_en = 1'b0;
        stall_sink = 1'b1;
        repeat (12) begin
            pulse_train = '{pulse_near(HdrMarkUs)};
            send_train();
        end
        idle_en = 1'b1;

        while (live_items < 750) begin
            send_random_capture();
        end
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        idle_en  = 1'b1;

        // Drain outstanding results, then check that none is missing
        waited = 0;
        while (board.pending_decodes.size() != 0 && waited < 10000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (board.pending_decodes.size() != 0) begin
            $display("%0t: result missing, expected %0d more beats, actual none",
                     $time, board.pending_decodes.size());
            board.faults++;
        end
        if (board.faults == 0)
            $display("ir_ac_frame_decoder test passed");
        else
            $display("ir_ac_frame_decoder test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #50000000;
        $display("ir_ac_frame_decoder test failed");
        $finish;
    end

endmodule
